>>> design/rgbe_rle_pkg.sv
package rgbe_rle_pkg;

  localparam int POS_BITS_DEF = 16;

  localparam int WIDTH_BITS = 16;
  localparam int BYTE_BITS = 8;

  // line width range for the per-channel scheme
  localparam logic [WIDTH_BITS-1:0] NEW_MIN_WIDTH = 16'd8;
  localparam logic [WIDTH_BITS-1:0] NEW_MAX_WIDTH = 16'h7fff;
  localparam logic [BYTE_BITS-1:0] RUN_THRESHOLD = 8'd128;
  localparam logic [BYTE_BITS-1:0] MARK_BYTE = 8'd2;
  localparam logic [BYTE_BITS-1:0] REPEAT_BYTE = 8'd1;

  // old scheme repeat shift held as a step count: shift = 8 * step, step 4 = runs forbidden
  localparam logic [2:0] SHIFT_OFF = 3'd4;

  // code byte state of a plane
  localparam logic [8:0] CS_IDLE = 9'h000;
  localparam logic [1:0] CS_RUN_TAG = 2'b10;
  localparam logic [1:0] CS_DRAIN_TAG = 2'b11;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END = 1'b1;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_OVERRUN = 2'd1;
  localparam logic [1:0] ERR_RUN = 2'd2;
  localparam logic [1:0] ERR_TRUNC = 2'd3;

  localparam logic [2:0] LANE_BLUE = 3'd0;
  localparam logic [2:0] LANE_GREEN = 3'd1;
  localparam logic [2:0] LANE_RED = 3'd2;
  localparam logic [2:0] LANE_EXP = 3'd3;
  localparam logic [2:0] LANE_ALL = 3'd4;

  typedef enum logic [3:0] {
    MODE_START = 4'b0001,
    MODE_HEAD  = 4'b0010,
    MODE_OLD   = 4'b0100,
    MODE_NEW   = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  phase;
    logic [23:0] held;
    logic [31:0] prev;
    logic [2:0]  shift_step;
    logic [1:0]  plane;
    logic [8:0]  code;
    logic        sticky;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    mode: MODE_START,
    phase: 2'd0,
    held: 24'd0,
    prev: 32'd0,
    shift_step: SHIFT_OFF,
    plane: 2'd0,
    code: CS_IDLE,
    sticky: 1'b0
  };

  typedef struct packed {
    logic [15:0] start_pixel;
    logic [15:0] run_length;
    logic [2:0]  lane;
    logic [7:0]  blue_byte;
    logic [7:0]  green_byte;
    logic [7:0]  red_byte;
    logic [7:0]  exp_byte;
    logic        line_done;
    logic [1:0]  error_code;
  } res_t;

  // planes arrive red, green, blue, exponent
  function automatic logic [2:0] plane_lane(input logic [1:0] plane);
    logic [2:0] lane;
    case (plane)
      2'd0: lane = LANE_RED;
      2'd1: lane = LANE_GREEN;
      2'd2: lane = LANE_BLUE;
      default: lane = LANE_EXP;
    endcase
    return lane;
  endfunction

endpackage

>>> design/rgbe_rle_step.sv
module rgbe_rle_step
  import rgbe_rle_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  dec_state_t          st,
  input  logic [POS_BITS-1:0] pos,
  input  logic [15:0]         width,
  input  logic                req_type,
  input  logic [7:0]          data_byte,
  output dec_state_t          st_next,
  output logic [POS_BITS-1:0] pos_next,
  output logic                res_valid,
  output res_t                res
);

  localparam int CW = (POS_BITS > WIDTH_BITS) ? POS_BITS : WIDTH_BITS;

  logic [15:0]         room;
  logic [7:0]          hb_r, hb_g, hb_b;
  logic [31:0]         pix;
  logic [15:0]         run_cnt;
  logic                run_over;
  logic [2:0]          new_lane;
  logic                adv_old, adv_new;
  logic [15:0]         adv_n;
  logic [POS_BITS-1:0] pos_sum;
  logic                reach;

  assign room = (CW'(width) > CW'(pos)) ? 16'(CW'(width) - CW'(pos)) : 16'd0;

  assign hb_r = st.held[7:0];
  assign hb_g = st.held[15:8];
  assign hb_b = st.held[23:16];
  assign pix = {data_byte, hb_r, hb_g, hb_b};

  // old scheme run length: count = byte << (8 * step)
  always_comb begin
    case (st.shift_step)
      3'd0: run_cnt = {8'd0, data_byte};
      3'd1: run_cnt = {data_byte, 8'd0};
      default: run_cnt = 16'd0;
    endcase
  end
  assign run_over = (st.shift_step >= 3'd2 && data_byte != 8'd0) || (run_cnt > room);

  assign new_lane = plane_lane(st.plane);

  always_comb begin
    st_next = st;
    pos_next = pos;
    res_valid = 1'b0;
    res = '0;
    adv_old = 1'b0;
    adv_new = 1'b0;
    adv_n = 16'd0;
    pos_sum = pos;
    reach = 1'b0;

    if (st.sticky) begin
      // silent until reset
    end else if (req_type == REQ_END) begin
      if (st.mode != MODE_START) begin
        res_valid = 1'b1;
        res.error_code = ERR_TRUNC;
        st_next.sticky = 1'b1;
      end
    end else begin
      case (st.mode)
        MODE_START: begin
          if (width >= NEW_MIN_WIDTH && width <= NEW_MAX_WIDTH && data_byte == MARK_BYTE) begin
            st_next.mode = MODE_HEAD;
          end else begin
            st_next.mode = MODE_OLD;
            st_next.shift_step = SHIFT_OFF;
          end
          st_next.held = {16'd0, data_byte};
          st_next.phase = 2'd1;
        end

        MODE_HEAD, MODE_OLD: begin
          if (st.phase != 2'd3) begin
            st_next.held = st.held | (24'(data_byte) << {st.phase, 3'b000});
            st_next.phase = st.phase + 2'd1;
          end else if (st.mode == MODE_HEAD && hb_g == MARK_BYTE && !hb_b[7]) begin
            st_next.mode = MODE_NEW;
            st_next.phase = 2'd0;
            st_next.held = 24'd0;
            st_next.plane = 2'd0;
            st_next.code = CS_IDLE;
            pos_next = '0;
          end else if (st.mode == MODE_OLD && hb_r == REPEAT_BYTE && hb_g == REPEAT_BYTE
                       && hb_b == REPEAT_BYTE) begin
            if (st.shift_step == SHIFT_OFF) begin
              res_valid = 1'b1;
              res.error_code = ERR_RUN;
              st_next.sticky = 1'b1;
            end else if (run_over) begin
              res_valid = 1'b1;
              res.error_code = ERR_OVERRUN;
              st_next.sticky = 1'b1;
            end else begin
              st_next.shift_step = st.shift_step + 3'd1;
              adv_old = 1'b1;
              adv_n = run_cnt;
              // zero-length run still moves the shift but writes nothing
              if (run_cnt != 16'd0) begin
                res_valid = 1'b1;
                res.start_pixel = 16'(pos);
                res.run_length = run_cnt;
                res.lane = LANE_ALL;
                {res.exp_byte, res.red_byte, res.green_byte, res.blue_byte} = st.prev;
              end
            end
          end else begin
            if (room == 16'd0) begin
              res_valid = 1'b1;
              res.error_code = ERR_OVERRUN;
              st_next.sticky = 1'b1;
            end else begin
              st_next.prev = pix;
              st_next.shift_step = 3'd0;
              adv_old = 1'b1;
              adv_n = 16'd1;
              res_valid = 1'b1;
              res.start_pixel = 16'(pos);
              res.run_length = 16'd1;
              res.lane = LANE_ALL;
              {res.exp_byte, res.red_byte, res.green_byte, res.blue_byte} = pix;
            end
          end
        end

        MODE_NEW: begin
          if (st.code == CS_IDLE) begin
            if (data_byte > RUN_THRESHOLD) begin
              st_next.code = {CS_RUN_TAG, data_byte[6:0]};
            end else if (16'(data_byte) > room) begin
              // literal does not fit: swallow its bytes, fail on the last
              st_next.code = {CS_DRAIN_TAG, 7'(data_byte - 8'd1)};
            end else begin
              st_next.code = {1'b0, data_byte};
            end
          end else if (st.code[8:7] == CS_DRAIN_TAG) begin
            if (st.code[6:0] == 7'd0) begin
              res_valid = 1'b1;
              res.error_code = ERR_OVERRUN;
              st_next.sticky = 1'b1;
            end else begin
              st_next.code = st.code - 9'd1;
            end
          end else if (st.code[8]) begin
            st_next.code = CS_IDLE;
            if (16'(st.code[6:0]) > room) begin
              res_valid = 1'b1;
              res.error_code = ERR_OVERRUN;
              st_next.sticky = 1'b1;
            end else begin
              adv_new = 1'b1;
              adv_n = 16'(st.code[6:0]);
              res_valid = 1'b1;
              res.start_pixel = 16'(pos);
              res.run_length = 16'(st.code[6:0]);
              res.lane = new_lane;
            end
          end else begin
            if (room == 16'd0) begin
              res_valid = 1'b1;
              res.error_code = ERR_OVERRUN;
              st_next.sticky = 1'b1;
            end else begin
              st_next.code = st.code - 9'd1;
              adv_new = 1'b1;
              adv_n = 16'd1;
              res_valid = 1'b1;
              res.start_pixel = 16'(pos);
              res.run_length = 16'd1;
              res.lane = new_lane;
            end
          end
          if (adv_new) begin
            res.blue_byte = (new_lane == LANE_BLUE) ? data_byte : 8'd0;
            res.green_byte = (new_lane == LANE_GREEN) ? data_byte : 8'd0;
            res.red_byte = (new_lane == LANE_RED) ? data_byte : 8'd0;
            res.exp_byte = (new_lane == LANE_EXP) ? data_byte : 8'd0;
          end
        end

        default: begin
          st_next = st;
        end
      endcase

      pos_sum = POS_BITS'(CW'(pos) + CW'(adv_n));
      reach = CW'(pos_sum) >= CW'(width);

      // position update, end of plane and end of line
      if (adv_old) begin
        pos_next = pos_sum;
        st_next.phase = 2'd0;
        st_next.held = 24'd0;
        st_next.mode = MODE_OLD;
      end
      if (adv_new) begin
        pos_next = pos_sum;
        if (reach && st.plane != 2'd3) begin
          st_next.plane = st.plane + 2'd1;
          st_next.code = CS_IDLE;
          pos_next = '0;
        end
      end
      if ((adv_old || (adv_new && st.plane == 2'd3)) && reach) begin
        st_next.mode = MODE_START;
        st_next.phase = 2'd0;
        st_next.held = 24'd0;
        st_next.shift_step = SHIFT_OFF;
        st_next.plane = 2'd0;
        st_next.code = CS_IDLE;
        pos_next = '0;
        res.line_done = res_valid;
      end
    end
  end

endmodule

>>> design/rgbe_rle_outbuf.sv
module rgbe_rle_outbuf
  import rgbe_rle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic take;
  logic skid_valid;
  res_t skid_data;

  assign take = out_valid & out_ready;
  // push is never asserted while the skid stage holds a word
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> design/rgbe_scanline_rle_decoder_core.sv
// RGBE scanline run-length decoder.
// s_* carries the encoded pixel data of a scanline sequence, one byte per word;
// s_tuser = 1 marks end of data instead of a byte. m_* carries write descriptors
// for a line buffer: start pixel, run length, lane and byte values, with m_tlast
// on the write that completes a scanline and a nonzero error code on a failure.
// An error word is the last word until reset.
// cfg_wr_en/cfg_wr_data set the line width; write it only while the block is idle.
// Throughput: one byte per cycle while s_tready is high, every byte handled by a single decode step.
// A write descriptor is registered in the output register, or in the skid word while that one is held, before m_tvalid.
// The output register plus one skid word let input continue while the receiver
// stalls; s_tready falls only once both hold a word, and returns the cycle after
// the receiver takes one.
// Reset (rst, synchronous) clears all decode state, drops buffered words and sets
// the line width to 1.
module rgbe_scanline_rle_decoder_core
  import rgbe_rle_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data, // line_width
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // data_byte
  input  logic        s_tuser,     // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,     // start_pixel, run_length, blue, green, red, exp
  output logic [4:0]  m_tuser,     // lane, error_code
  output logic        m_tlast      // line_done
);

  logic [15:0]         line_width;
  dec_state_t          st, st_next;
  logic [POS_BITS-1:0] pixel_pos, pixel_pos_next;
  logic                accept;
  logic                res_valid;
  res_t                res, out_res;

  assign accept = s_tvalid & s_tready;

  rgbe_rle_step #(
    .POS_BITS(POS_BITS)
  ) u_step (
    .st        (st),
    .pos       (pixel_pos),
    .width     (line_width),
    .req_type  (s_tuser),
    .data_byte (s_tdata),
    .st_next   (st_next),
    .pos_next  (pixel_pos_next),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 16'd1;
    end else if (cfg_wr_en) begin
      line_width <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
      pixel_pos <= '0;
    end else if (accept) begin
      st <= st_next;
      pixel_pos <= pixel_pos_next;
    end
  end

  rgbe_rle_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept & res_valid),
    .push_data (res),
    .space     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.exp_byte, out_res.red_byte, out_res.green_byte,
                    out_res.blue_byte, out_res.run_length, out_res.start_pixel};
  assign m_tuser = {out_res.error_code, out_res.lane};
  assign m_tlast = out_res.line_done;

endmodule

>>> design/rgbe_rle_checker.sv
module rgbe_rle_checker
  import rgbe_rle_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [4:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output word changed while stalled");

  // an error word carries no write
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4:3] != ERR_NONE |-> m_tdata == 64'd0 && !m_tlast
      && m_tuser[2:0] == LANE_BLUE)
    else $error("error word carries write fields");

  // a write covers at least one pixel
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4:3] == ERR_NONE |-> m_tdata[31:16] != 16'd0)
    else $error("write of zero length");

  // nothing follows an error word
  a_silent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser[4:3] != ERR_NONE |=> !m_tvalid)
    else $error("word after error");

endmodule

bind rgbe_scanline_rle_decoder_core rgbe_rle_checker u_chk (.*);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rgbe_rle_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_WORDS = 1300;
  localparam int REPORT_MAX = 10;
  localparam logic [7:0] EMPTY_LITERAL = 8'h00;

  typedef enum int {
    FAULT_CUT_PIXEL,
    FAULT_RUN_AT_START,
    FAULT_RUN_EXHAUSTED,
    FAULT_OLD_OVERRUN,
    FAULT_LIT_DRAIN,
    FAULT_LIT_CUT,
    FAULT_RUN_OVERRUN,
    FAULT_ZERO_WIDTH,
    FAULT_SHRINK
  } fault_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;

  // decoder state as the scoreboard sees it
  logic [15:0] mdl_width;
  mode_t       mdl_mode;
  logic [1:0]  mdl_phase;
  logic [23:0] mdl_held;
  logic [31:0] mdl_prev;
  logic [2:0]  mdl_shift_step;
  logic [15:0] mdl_pos;
  logic [1:0]  mdl_plane;
  logic [8:0]  mdl_code;
  bit          mdl_sticky;
  res_t        expected_writes[$];

  int unsigned gen_width = 1;
  bit          idle_off = 1'b0;
  int unsigned words_sent = 0;
  int unsigned lines_sent = 0;
  int unsigned width_writes = 0;
  int unsigned writes_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  fault_t      closing_fault;

  rgbe_scanline_rle_decoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // write prediction

  function automatic void queue_write(input logic [15:0] start, input logic [15:0] len,
                                      input logic [2:0] lane, input logic [31:0] pix,
                                      input logic done, input logic [1:0] err);
    res_t w;
    w.start_pixel = start;
    w.run_length = len;
    w.lane = lane;
    w.blue_byte = pix[7:0];
    w.green_byte = pix[15:8];
    w.red_byte = pix[23:16];
    w.exp_byte = pix[31:24];
    w.line_done = done;
    w.error_code = err;
    expected_writes.push_back(w);
  endfunction

  function automatic void raise_error(input logic [1:0] err);
    mdl_sticky = 1'b1;
    queue_write('0, '0, LANE_BLUE, '0, 1'b0, err);
  endfunction

  function automatic void close_line();
    mdl_mode = MODE_START;
    mdl_phase = '0;
    mdl_held = '0;
    mdl_shift_step = SHIFT_OFF;
    mdl_pos = '0;
    mdl_plane = '0;
    mdl_code = CS_IDLE;
  endfunction

  function automatic logic [31:0] pixels_left();
    return (mdl_width > mdl_pos) ? 32'(mdl_width - mdl_pos) : 32'd0;
  endfunction

  function automatic logic advance_old(input logic [31:0] n);
    mdl_pos = 16'(mdl_pos + n);
    mdl_phase = '0;
    mdl_held = '0;
    mdl_mode = MODE_OLD;
    if (mdl_pos >= mdl_width) begin
      close_line();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic advance_plane(input logic [31:0] n);
    mdl_pos = 16'(mdl_pos + n);
    if (mdl_pos >= mdl_width) begin
      if (mdl_plane == 2'd3) begin
        close_line();
        return 1'b1;
      end
      mdl_plane++;
      mdl_pos = '0;
      mdl_code = CS_IDLE;
    end
    return 1'b0;
  endfunction

  function automatic void write_pixel(input logic [31:0] pix);
    logic [15:0] start;
    logic        done;
    start = mdl_pos;
    if (pixels_left() == 0) begin
      raise_error(ERR_OVERRUN);
      return;
    end
    mdl_prev = pix;
    mdl_shift_step = '0;
    done = advance_old(1);
    queue_write(start, 16'd1, LANE_ALL, pix, done, ERR_NONE);
  endfunction

  function automatic void decode_word(input logic req, input logic [7:0] d);
    logic [7:0]  r, g, b;
    logic [15:0] start;
    logic [31:0] count;
    logic [2:0]  lane;
    logic        done;
    if (mdl_sticky)
      return;
    if (req == REQ_END) begin
      if (mdl_mode != MODE_START)
        raise_error(ERR_TRUNC);
      return;
    end
    case (mdl_mode)
      MODE_START: begin
        if (mdl_width >= NEW_MIN_WIDTH && mdl_width <= NEW_MAX_WIDTH && d == MARK_BYTE) begin
          mdl_mode = MODE_HEAD;
        end else begin
          mdl_mode = MODE_OLD;
          mdl_shift_step = SHIFT_OFF;
        end
        mdl_held = {16'd0, d};
        mdl_phase = 2'd1;
      end
      MODE_HEAD, MODE_OLD: begin
        if (mdl_phase < 2'd3) begin
          mdl_held = mdl_held | (24'(d) << (8 * mdl_phase));
          mdl_phase++;
          return;
        end
        r = mdl_held[7:0];
        g = mdl_held[15:8];
        b = mdl_held[23:16];
        if (mdl_mode == MODE_HEAD && g == MARK_BYTE && !b[7]) begin
          mdl_mode = MODE_NEW;
          mdl_phase = '0;
          mdl_held = '0;
          mdl_pos = '0;
          mdl_plane = '0;
          mdl_code = CS_IDLE;
          return;
        end
        if (mdl_mode == MODE_OLD && r == REPEAT_BYTE && g == REPEAT_BYTE && b == REPEAT_BYTE)
        begin
          if (mdl_shift_step >= SHIFT_OFF) begin
            raise_error(ERR_RUN);
            return;
          end
          count = 32'(d) << (8 * mdl_shift_step);
          if (count > pixels_left()) begin
            raise_error(ERR_OVERRUN);
            return;
          end
          mdl_shift_step++;
          start = mdl_pos;
          done = advance_old(count);
          // a zero repeat still bumps the shift but writes nothing
          if (count != 0)
            queue_write(start, count[15:0], LANE_ALL, mdl_prev, done, ERR_NONE);
          return;
        end
        write_pixel({d, r, g, b});
      end
      default: begin
        case (mdl_plane)
          2'd0: lane = LANE_RED;
          2'd1: lane = LANE_GREEN;
          2'd2: lane = LANE_BLUE;
          default: lane = LANE_EXP;
        endcase
        if (mdl_code == CS_IDLE) begin
          if (d > RUN_THRESHOLD)
            mdl_code = {CS_RUN_TAG, d[6:0]};
          else if (32'(d) > pixels_left())
            mdl_code = {CS_DRAIN_TAG, 7'(d - 8'd1)};
          else
            mdl_code = {1'b0, d};
        end else if (mdl_code[8:7] == CS_DRAIN_TAG) begin
          // oversized literal: swallow its bytes, fail on the last one
          if (mdl_code[6:0] == 0)
            raise_error(ERR_OVERRUN);
          else
            mdl_code--;
        end else if (mdl_code[8]) begin
          count = 32'(mdl_code[6:0]);
          mdl_code = CS_IDLE;
          if (count > pixels_left()) begin
            raise_error(ERR_OVERRUN);
          end else begin
            start = mdl_pos;
            done = advance_plane(count);
            queue_write(start, count[15:0], lane, 32'(d) << (8 * lane), done, ERR_NONE);
          end
        end else if (pixels_left() == 0) begin
          raise_error(ERR_OVERRUN);
        end else begin
          mdl_code--;
          start = mdl_pos;
          done = advance_plane(1);
          queue_write(start, 16'd1, lane, 32'(d) << (8 * lane), done, ERR_NONE);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking

  function automatic string describe(input res_t w);
    return $sformatf("start=%0d len=%0d lane=%0d b=%h g=%h r=%h e=%h last=%b err=%0d",
                     w.start_pixel, w.run_length, w.lane, w.blue_byte, w.green_byte,
                     w.red_byte, w.exp_byte, w.line_done, w.error_code);
  endfunction

  function automatic void check_write(input res_t want, input res_t got);
    writes_checked++;
    if (want.start_pixel !== got.start_pixel || want.run_length !== got.run_length ||
        want.lane !== got.lane || want.blue_byte !== got.blue_byte ||
        want.green_byte !== got.green_byte || want.red_byte !== got.red_byte ||
        want.exp_byte !== got.exp_byte || want.line_done !== got.line_done ||
        want.error_code !== got.error_code) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("write %0d mismatch", writes_checked);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endfunction

  always @(posedge clk) begin : write_scoreboard
    res_t got;
    if (rst) begin
      mdl_width = 16'd1;
      mdl_prev = '0;
      mdl_sticky = 1'b0;
      close_line();
      expected_writes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.start_pixel = m_tdata[15:0];
        got.run_length = m_tdata[31:16];
        got.blue_byte = m_tdata[39:32];
        got.green_byte = m_tdata[47:40];
        got.red_byte = m_tdata[55:48];
        got.exp_byte = m_tdata[63:56];
        got.lane = m_tuser[2:0];
        got.error_code = m_tuser[4:3];
        got.line_done = m_tlast;
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected write: %s", describe(got));
        end else begin
          check_write(expected_writes.pop_front(), got);
        end
      end
      if (cfg_wr_en)
        mdl_width = cfg_wr_data;
      if (s_tvalid && s_tready)
        decode_word(s_tuser, s_tdata);
    end
  end

  always @(posedge clk)
    m_tready <= !rst && (idle_off || $urandom_range(99) >= 37);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d writes outstanding", cycle_count,
               expected_writes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus

  task automatic send_word(input logic req, input logic [7:0] b);
    while (!idle_off && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(REQ_DATA, b);
  endtask

  task automatic send_end();
    send_word(REQ_END, 8'($urandom));
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] e);
    send_byte(r);
    send_byte(g);
    send_byte(b);
    send_byte(e);
  endtask

  task automatic send_repeat(input logic [7:0] n);
    send_pixel(REPEAT_BYTE, REPEAT_BYTE, REPEAT_BYTE, n);
  endtask

  task automatic send_header();
    send_pixel(MARK_BYTE, MARK_BYTE, 8'($urandom_range(127)), 8'($urandom));
  endtask

  // wait for every write to drain, plus a little slack for the output stage
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_writes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_width(input logic [15:0] w);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gen_width = 32'(w);
    width_writes++;
  endtask

  task automatic old_line();
    int unsigned pos, left, top, n, step;
    logic [7:0]  r, g, b;
    bit          first;
    pos = 0;
    step = 32'(SHIFT_OFF);
    first = 1'b1;
    while (pos < gen_width) begin
      left = gen_width - pos;
      if (step < 32'(SHIFT_OFF) && $urandom_range(99) < 40) begin
        top = left >> (8 * step);
        if (top > 255)
          top = 255;
        n = ($urandom_range(99) < 60) ? top : $urandom_range(top);
        send_repeat(8'(n));
        pos += n << (8 * step);
        step++;
      end else begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        if (first && $urandom_range(3) == 0) begin
          r = MARK_BYTE;
          if ($urandom_range(1) == 0)
            g = MARK_BYTE;
        end
        if (r == REPEAT_BYTE && g == REPEAT_BYTE && b == REPEAT_BYTE)
          b = 8'hfe;
        // keep a leading 2,2 from qualifying as a per-channel header
        if (first && r == MARK_BYTE && g == MARK_BYTE)
          b[7] = 1'b1;
        send_pixel(r, g, b, 8'($urandom));
        pos++;
        step = 0;
      end
      first = 1'b0;
    end
    lines_sent++;
  endtask

  task automatic new_line();
    int unsigned pos, left, n, k, plane;
    send_header();
    for (plane = 0; plane < 4; plane++) begin
      pos = 0;
      while (pos < gen_width) begin
        left = gen_width - pos;
        k = $urandom_range(99);
        if (k < 8) begin
          send_byte(EMPTY_LITERAL);
        end else if (k < 55) begin
          n = (left > 127) ? 127 : left;
          if ($urandom_range(2) != 0)
            n = $urandom_range(n, 1);
          send_byte(RUN_THRESHOLD | 8'(n));
          send_byte(8'($urandom));
          pos += n;
        end else begin
          n = (left > 128) ? 128 : left;
          if ($urandom_range(9) != 0)
            n = $urandom_range((n > 8) ? 8 : n, 1);
          send_byte(8'(n));
          repeat (n) send_byte(8'($urandom));
          pos += n;
        end
      end
    end
    lines_sent++;
  endtask

  // width 1 after reset: every pixel is a whole line
  task automatic test_single_pixel_lines();
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    send_pixel(MARK_BYTE, MARK_BYTE, 8'h00, 8'h7f);
    send_end();
    settle();
  endtask

  task automatic test_old_repeats();
    set_width(16'd7);
    send_pixel(8'h10, 8'h20, 8'h30, 8'h40);
    send_repeat(8'd3);
    send_repeat(8'd0);
    send_pixel(8'h55, 8'haa, 8'h01, 8'h80);
    send_repeat(8'd2);
    settle();
    // widest line: shift walks 0, 8, 16, 24 and then is reset by a pixel
    set_width(16'hffff);
    send_pixel(8'h01, 8'h01, 8'h02, 8'h03);
    send_repeat(8'd255);
    send_repeat(8'd254);
    send_repeat(8'd0);
    send_repeat(8'd0);
    send_pixel(8'hc0, 8'h0c, 8'h01, 8'h01);
    send_repeat(8'd254);
    settle();
    // just above the per-channel range, so 2,2,0 is a plain pixel
    set_width(16'h8000);
    send_pixel(MARK_BYTE, MARK_BYTE, 8'h00, 8'h91);
    send_repeat(8'd255);
    send_repeat(8'd127);
    lines_sent += 3;
    settle();
  endtask

  task automatic test_channel_planes();
    set_width(NEW_MIN_WIDTH);
    send_pixel(MARK_BYTE, MARK_BYTE, 8'h7f, 8'h88);
    send_byte(RUN_THRESHOLD | 8'd8);
    send_byte(8'hff);
    send_byte(EMPTY_LITERAL);
    send_byte(8'd8);
    send_pixel(8'h00, 8'hff, 8'h80, 8'h7f);
    send_pixel(8'h01, 8'hfe, 8'h55, 8'haa);
    send_byte(8'd3);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(RUN_THRESHOLD | 8'd5);
    send_byte(8'h80);
    send_byte(RUN_THRESHOLD | 8'd4);
    send_byte(8'h01);
    send_byte(8'd4);
    send_pixel(8'h9a, 8'hbc, 8'hde, 8'hf0);
    settle();
    // top of the per-channel range, narrowed part way through the red plane
    set_width(NEW_MAX_WIDTH);
    send_header();
    send_byte(8'hff);
    send_byte(8'h11);
    send_byte(8'hff);
    send_byte(8'h22);
    settle();
    set_width(16'd256);
    send_byte(RUN_THRESHOLD | 8'd2);
    send_byte(8'h33);
    repeat (3) begin
      send_byte(8'hff);
      send_byte(8'($urandom));
      send_byte(8'hff);
      send_byte(8'($urandom));
      send_byte(RUN_THRESHOLD | 8'd2);
      send_byte(8'($urandom));
    end
    lines_sent += 2;
    settle();
  endtask

  task automatic test_midline_width_change();
    set_width(16'd20);
    repeat (3) send_pixel(8'($urandom), 8'h40, 8'h41, 8'($urandom));
    settle();
    set_width(16'd5);
    repeat (2) send_pixel(8'h42, 8'($urandom), 8'($urandom), 8'h43);
    settle();
    // the plane ends at the new width and the rest of the literal is dropped
    set_width(16'd16);
    send_header();
    send_byte(8'd10);
    repeat (4) send_byte(8'($urandom));
    settle();
    set_width(16'd6);
    repeat (2) send_byte(8'($urandom));
    repeat (3) begin
      send_byte(RUN_THRESHOLD | 8'd6);
      send_byte(8'($urandom));
    end
    lines_sent += 2;
    settle();
  endtask

  task automatic test_fallback_header();
    set_width(16'd16);
    send_pixel(MARK_BYTE, MARK_BYTE, 8'h80, 8'h21);
    send_pixel(MARK_BYTE, 8'h05, 8'h00, 8'h09);
    send_repeat(8'd14);
    send_end();
    lines_sent++;
    settle();
  endtask

  task automatic test_random_lines();
    int unsigned first_word, pick, lines;
    logic [15:0] w;
    first_word = words_sent;
    while (words_sent < first_word + RANDOM_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 10)
        w = 16'($urandom_range(7, 1));
      else if (pick < 60)
        w = 16'($urandom_range(40, 8));
      else if (pick < 80)
        w = 16'($urandom_range(300, 41));
      else if (pick < 88)
        w = 16'($urandom_range(65535, 32768));
      else if (pick < 94)
        w = 16'($urandom_range(1000, 301));
      else begin
        case ($urandom_range(3))
          0: w = 16'hffff;
          1: w = NEW_MAX_WIDTH;
          2: w = NEW_MIN_WIDTH;
          default: w = NEW_MIN_WIDTH - 16'd1;
        endcase
      end
      settle();
      set_width(w);
      lines = $urandom_range(4, 1);
      repeat (lines) begin
        // long stretch in the middle with both sides streaming flat out
        idle_off = (words_sent - first_word >= 500 && words_sent - first_word < 800);
        if (w >= NEW_MIN_WIDTH && w <= 16'd400 && $urandom_range(99) < 60)
          new_line();
        else
          old_line();
        if ($urandom_range(4) == 0)
          send_end();
      end
    end
    idle_off = 1'b0;
    settle();
  endtask

  // errors are sticky, so exactly one kind is provoked and only at the very end
  task automatic test_sticky_error();
    closing_fault = fault_t'($urandom_range(FAULT_SHRINK));
    case (closing_fault)
      FAULT_CUT_PIXEL: begin
        set_width(16'($urandom_range(40, 2)));
        send_byte(8'h33);
        send_byte(8'($urandom));
        send_end();
      end
      FAULT_RUN_AT_START: begin
        set_width(16'd10);
        send_repeat(8'd3);
      end
      FAULT_RUN_EXHAUSTED: begin
        set_width(16'd10);
        send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        repeat (4) send_repeat(8'd0);
        send_repeat(8'd5);
      end
      FAULT_OLD_OVERRUN: begin
        set_width(16'd10);
        send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        send_repeat(8'd20);
      end
      FAULT_LIT_DRAIN: begin
        set_width(NEW_MIN_WIDTH);
        send_header();
        send_byte(8'd10);
        repeat (10) send_byte(8'($urandom));
      end
      FAULT_LIT_CUT: begin
        set_width(NEW_MIN_WIDTH);
        send_header();
        send_byte(8'd10);
        repeat (4) send_byte(8'($urandom));
        send_end();
      end
      FAULT_RUN_OVERRUN: begin
        set_width(NEW_MIN_WIDTH);
        send_header();
        send_byte(RUN_THRESHOLD | 8'd16);
        send_byte(8'($urandom));
      end
      FAULT_ZERO_WIDTH: begin
        set_width(16'd0);
        send_pixel(8'h44, 8'h55, 8'h66, 8'h77);
      end
      default: begin
        set_width(16'd20);
        repeat (3) send_pixel(8'h21, 8'h43, 8'h65, 8'h87);
        settle();
        set_width(16'd2);
        send_pixel(8'h21, 8'h43, 8'h65, 8'h87);
      end
    endcase
    // decoder must stay silent from here on
    repeat (6) send_byte(8'($urandom));
    send_end();
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_single_pixel_lines();
    test_old_repeats();
    test_channel_planes();
    test_midline_width_change();
    test_fallback_header();
    test_random_lines();
    test_sticky_error();
    while (expected_writes.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d words sent over about %0d scanlines and %0d width settings",
             words_sent, lines_sent, width_writes);
    $display("%0d write descriptors checked, closing fault %s, %0d mismatches",
             writes_checked, closing_fault.name(), mismatches);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
